[design/assert_macros.svh]
// Assertion macros for the port-level checker of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed during reset");

`endif

[design/udpck_pkg.sv]
// Types, constants and the one's-complement adder for the IPv4/UDP checksum engine.
// No dependencies.
`default_nettype none

package udpck_pkg;

    localparam logic [15:0] UDP_PROTO    = 16'h0011;
    localparam logic [15:0] IP_CSUM_POS  = 16'd10;
    localparam logic [15:0] UDP_CSUM_OFS = 16'd6;
    localparam logic [15:0] ADDR_FIRST   = 16'd12;
    localparam logic [15:0] ADDR_END     = 16'd20;
    localparam logic [15:0] WORD_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_udpck_in;

    typedef struct packed {
        logic [15:0] ip_header_checksum;
        logic [15:0] udp_checksum;
        logic        short_packet;
    } t_udpck_out;

    typedef struct packed {
        logic [15:0] header_sum;
        logic [15:0] payload_sum;
        logic [15:0] datagram_length;
        logic [5:0]  header_bytes;
        logic [16:0] received;
    } t_udpck_snap;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

[design/udpck_accum.sv]
// Input register and per-byte accumulation of header and UDP sums.
// Depends on udpck_pkg; hands a snapshot of the final state to udpck_final.
`default_nettype none

module udpck_accum import udpck_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_udpck_in   i_in_data,
    output logic             o_snap_valid,
    input  wire logic        i_snap_ready,
    output t_udpck_snap      o_snap
);

    logic        r_in_valid;
    t_udpck_in   r_in;
    logic        r_snap_valid;
    t_udpck_snap r_snap;

    logic [15:0] r_pos, r_dl, r_hsum, r_psum;
    logic [5:0]  r_hb;
    logic [7:0]  r_pend;

    logic [15:0] n_pos, n_dl, n_hsum, n_psum, psum_mid;
    logic [5:0]  n_hb;
    logic [7:0]  n_pend;

    logic        proc, last, odd, do_word, lo_in, hdr_add, udp_add, addr_add;
    logic [7:0]  b, hi, lo;
    logic [15:0] q, word, udp_word, hb_ext;

    assign proc = r_in_valid && (!r_in.last_byte || !r_snap_valid || i_snap_ready);
    assign o_in_ready = !r_in_valid || proc;
    assign o_snap_valid = r_snap_valid;
    assign o_snap = r_snap;

    always_comb begin
        b    = r_in.data_byte;
        last = r_in.last_byte;
        odd  = r_pos[0];

        n_hb = (r_pos == 16'd0) ? {b[3:0], 2'b00} : r_hb;
        if (r_pos == 16'd2) begin
            n_dl = {b, r_dl[7:0]};
        end else if (r_pos == 16'd3) begin
            n_dl = {r_dl[15:8], b};
        end else begin
            n_dl = r_dl;
        end
        hb_ext = {10'd0, n_hb};

        q        = {r_pos[15:1], 1'b0};
        hi       = odd ? r_pend : b;
        lo       = odd ? b : 8'h00;
        lo_in    = odd && (r_pos < n_dl);
        do_word  = odd || last;
        word     = {hi, lo};
        udp_word = lo_in ? word : {hi, 8'h00};

        hdr_add  = do_word && (q < hb_ext) && (q != IP_CSUM_POS);
        udp_add  = do_word && (q >= hb_ext) && (q < n_dl) && (q != hb_ext + UDP_CSUM_OFS);
        addr_add = do_word && (q >= ADDR_FIRST) && (q < ADDR_END);

        n_hsum   = hdr_add ? oc_add(r_hsum, word) : r_hsum;
        psum_mid = udp_add ? oc_add(r_psum, udp_word) : r_psum;
        n_psum   = addr_add ? oc_add(psum_mid, word) : psum_mid;

        n_pend = odd ? r_pend : b;
        n_pos  = (r_pos == WORD_MAX) ? r_pos : r_pos + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (proc && last) begin
            r_snap.header_sum      <= n_hsum;
            r_snap.payload_sum     <= n_psum;
            r_snap.datagram_length <= n_dl;
            r_snap.header_bytes    <= n_hb;
            r_snap.received        <= {1'b0, r_pos} + 17'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_pos        <= '0;
            r_hb         <= '0;
            r_dl         <= '0;
            r_hsum       <= '0;
            r_psum       <= '0;
            r_pend       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc && last) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
            if (proc) begin
                if (last) begin
                    r_pos  <= '0;
                    r_hb   <= '0;
                    r_dl   <= '0;
                    r_hsum <= '0;
                    r_psum <= '0;
                    r_pend <= '0;
                end else begin
                    r_pos  <= n_pos;
                    r_hb   <= n_hb;
                    r_dl   <= n_dl;
                    r_hsum <= n_hsum;
                    r_psum <= n_psum;
                    r_pend <= n_pend;
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/udpck_final.sv]
// Final checksum formation and output register.
// Depends on udpck_pkg; fed by udpck_accum.
`default_nettype none

module udpck_final import udpck_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_snap_valid,
    output logic             o_snap_ready,
    input  wire t_udpck_snap i_snap,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_udpck_out       o_out_data
);

    logic       r_out_valid;
    t_udpck_out r_out;
    t_udpck_out n_out;

    logic [15:0] udp_len, s1, s2, udpc;

    assign o_snap_ready = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    always_comb begin
        udp_len = i_snap.datagram_length - {10'd0, i_snap.header_bytes};
        s1      = oc_add(i_snap.payload_sum, UDP_PROTO);
        s2      = oc_add(s1, udp_len);
        udpc    = ~s2;
        n_out.ip_header_checksum = ~i_snap.header_sum;
        n_out.udp_checksum       = (udpc == 16'd0) ? WORD_MAX : udpc;
        n_out.short_packet       = i_snap.received < {1'b0, i_snap.datagram_length};
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_ready && i_snap_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_snap_ready) begin
            r_out_valid <= i_snap_valid;
        end
    end

endmodule

`default_nettype wire

[design/ipv4_udp_checksum_engine.sv]
// Top level of the IPv4/UDP checksum engine.
// Depends on udpck_pkg, udpck_accum and udpck_final.
//
// Usage:
// - Input channel (i_in_valid/o_in_ready/i_in_data): one datagram byte per
//   transfer, starting at IPv4 header byte 0; last_byte marks the final byte.
// - Output channel (o_out_valid/i_out_ready/o_out_data): one result per
//   datagram with the IP header checksum, the UDP checksum (pseudo-header
//   included, zero sent as 0xFFFF) and the short_packet flag.
// - Throughput: one byte per cycle, back to back, across datagram borders,
//   unless a last byte must wait for the snapshot register (see below).
// - Result path: input register, snapshot register, then output register.
// - Reset (synchronous, active low) drops all held transfers and clears the
//   running sums, the byte position and the length fields.
// - A stalled receiver holds the result; a second result waits in the
//   snapshot register, and bytes keep flowing until a third last byte
//   reaches the input register, at which point o_in_ready drops.
`default_nettype none

module ipv4_udp_checksum_engine import udpck_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_udpck_in  i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_udpck_out      o_out_data
);

    logic        snap_valid;
    logic        snap_ready;
    t_udpck_snap snap;

    udpck_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    udpck_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

[design/udpck_checker.sv]
// Port-level checks on the checksum engine, bound to the top level.
// Depends on udpck_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

module udpck_checker import udpck_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire t_udpck_out o_out_data
);

    `ASSERT_CLK_NR(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid)
    `ASSERT_CLK(a_udp_nonzero, i_clk, i_rst_n, o_out_valid |-> o_out_data.udp_checksum != 16'd0)
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data))

endmodule

bind ipv4_udp_checksum_engine udpck_checker u_udpck_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[sim/udpck_checker.sv]
// Checker for the IPv4/UDP checksum engine: watches both channels, predicts the
// checksum result of each datagram and compares it with the block's output.
// Depends on udpck_pkg.
module udpck_scoreboard
    import udpck_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_udpck_in  i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_udpck_out i_out_data,
    output int         o_pending,
    output int         o_err_count
);

    logic [15:0] byte_pos;
    logic [5:0]  hdr_len;
    logic [15:0] total_len;
    logic [15:0] hdr_sum;
    logic [15:0] udp_sum;
    logic [7:0]  even_byte;
    t_udpck_out  sums_q[$];
    int          errs = 0;

    initial begin
        o_pending   = 0;
        o_err_count = 0;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] t;
        t = {16'd0, a} + {16'd0, b};
        return t[15:0] + t[31:16];
    endfunction

    task automatic clear_sums();
        byte_pos  = '0;
        hdr_len   = '0;
        total_len = '0;
        hdr_sum   = '0;
        udp_sum   = '0;
        even_byte = '0;
    endtask

    // Word at even position q: header sum, UDP data sum, pseudo-header addresses.
    task automatic fold_word(input logic [15:0] q, input logic [7:0] hi, input logic [7:0] lo,
                             input logic lo_ok);
        logic [15:0] w;
        logic [15:0] hl;
        w  = {hi, lo};
        hl = {10'd0, hdr_len};
        if (q < hl && q != IP_CSUM_POS)
            hdr_sum = ones_add(hdr_sum, w);
        if (q >= hl && q < total_len && q != hl + UDP_CSUM_OFS)
            udp_sum = ones_add(udp_sum, lo_ok ? w : {hi, 8'h00});
        if (q >= ADDR_FIRST && q < ADDR_END)
            udp_sum = ones_add(udp_sum, w);
    endtask

    always @(posedge i_clk) begin : monitor
        t_udpck_out  want;
        logic [7:0]  b;
        logic [15:0] p;
        logic [15:0] ulen;
        logic [15:0] s;
        if (!i_rst_n) begin
            clear_sums();
            sums_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sums_q.size() == 0) begin
                    $error("result transfer with no datagram outstanding: %h", i_out_data);
                    errs++;
                end else begin
                    want = sums_q.pop_front();
                    if (i_out_data.ip_header_checksum !== want.ip_header_checksum) begin
                        $error("ip_header_checksum expected %h actual %h",
                               want.ip_header_checksum, i_out_data.ip_header_checksum);
                        errs++;
                    end
                    if (i_out_data.udp_checksum !== want.udp_checksum) begin
                        $error("udp_checksum expected %h actual %h",
                               want.udp_checksum, i_out_data.udp_checksum);
                        errs++;
                    end
                    if (i_out_data.short_packet !== want.short_packet) begin
                        $error("short_packet expected %b actual %b",
                               want.short_packet, i_out_data.short_packet);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                b = i_in_data.data_byte;
                p = byte_pos;
                if (p == 16'd0)
                    hdr_len = {b[3:0], 2'b00};
                else if (p == 16'd2)
                    total_len[15:8] = b;
                else if (p == 16'd3)
                    total_len[7:0] = b;
                if (!p[0]) begin
                    even_byte = b;
                    if (i_in_data.last_byte)
                        fold_word(p, b, 8'h00, 1'b0);
                end else begin
                    fold_word(p - 16'd1, even_byte, b, p < total_len);
                end
                if (byte_pos != WORD_MAX)
                    byte_pos++;
                if (i_in_data.last_byte) begin
                    ulen = total_len - {10'd0, hdr_len};
                    s = ones_add(udp_sum, UDP_PROTO);
                    s = ones_add(s, ulen);
                    want.ip_header_checksum = ~hdr_sum;
                    want.udp_checksum       = (s == WORD_MAX) ? WORD_MAX : ~s;
                    want.short_packet       = ({1'b0, p} + 17'd1) < {1'b0, total_len};
                    sums_q.push_back(want);
                    clear_sums();
                end
            end
        end
        o_pending   <= sums_q.size();
        o_err_count <= errs;
    end

endmodule

[sim/ipv4_udp_checksum_engine_tb.sv]
// Testbench top for the IPv4/UDP checksum engine: drives datagram bytes and
// result backpressure, and gives the verdict. Depends on udpck_pkg,
// udpck_scoreboard and ipv4_udp_checksum_engine.
module ipv4_udp_checksum_engine_tb;
    import udpck_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_BYTES    = 540;
    localparam int DRAIN_CYCLES   = 10;

    typedef logic [7:0] t_bytes[$];
    typedef enum {SHAPE_EXACT, SHAPE_TRAILER, SHAPE_CUT, SHAPE_NOISE} t_shape;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_udpck_in  i_in_data;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_udpck_out o_out_data;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   bytes_sent  = 0;
    logic hold_req    = 1'b0;
    logic hold_taken  = 1'b0;
    int   hold_left   = 0;
    int   stall_count = 0;
    int   pending;
    int   err_count;

    ipv4_udp_checksum_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    udpck_scoreboard u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_pending   (pending),
        .o_err_count (err_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random backpressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t_udpck_in'{data_byte: b, last_byte: l};
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_bytes(input t_bytes pkt);
        foreach (pkt[i])
            push_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // IPv4/UDP framing with random content; nbytes may differ from tot.
    task automatic send_datagram(input logic [3:0] ihl, input logic [15:0] tot,
                                 input int nbytes);
        t_bytes      pkt;
        logic [15:0] ulen;
        int          hdr;
        hdr  = ihl * 4;
        ulen = tot - 16'(hdr);
        for (int i = 0; i < nbytes; i++) begin
            if (i == 0)
                pkt.push_back({4'h4, ihl});
            else if (i == 2)
                pkt.push_back(tot[15:8]);
            else if (i == 3)
                pkt.push_back(tot[7:0]);
            else if (i == 9)
                pkt.push_back(8'h11);
            else if (i == hdr + 4)
                pkt.push_back(ulen[15:8]);
            else if (i == hdr + 5)
                pkt.push_back(ulen[7:0]);
            else
                pkt.push_back(8'($urandom));
        end
        send_bytes(pkt);
    endtask

    task automatic send_random_packet();
        t_shape      shape;
        t_bytes      pkt;
        int          pick;
        int          n;
        logic [3:0]  ihl;
        logic [15:0] tot;
        pick  = $urandom_range(99);
        shape = (pick < 60) ? SHAPE_EXACT : (pick < 75) ? SHAPE_TRAILER :
                (pick < 85) ? SHAPE_CUT : SHAPE_NOISE;
        ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        tot = 16'(ihl * 4 + $urandom_range(8, 40));
        case (shape)
            SHAPE_EXACT:   send_datagram(ihl, tot, tot);
            SHAPE_TRAILER: send_datagram(ihl, tot, tot + $urandom_range(1, 6));
            SHAPE_CUT:     send_datagram(ihl, tot, $urandom_range(1, tot - 1));
            default: begin
                n = $urandom_range(1, 48);
                for (int i = 0; i < n; i++)
                    pkt.push_back(8'($urandom));
                if (n > 3 && $urandom_range(1)) begin
                    pkt[2] = 8'h00;
                    pkt[3] = 8'($urandom_range(0, 63));
                end
                send_bytes(pkt);
            end
        endcase
    endtask

    initial begin
        t_bytes pkt;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tiny streams, zero UDP sum, extremes, overlaps, odd tails.
        send_bytes('{8'h00});
        send_bytes('{8'hFF, 8'hFF});
        send_bytes('{8'h4F, 8'h00, 8'h00});
        send_bytes('{8'h00, 8'h00, 8'h7F, 8'hF7});
        pkt = {};
        repeat (28) pkt.push_back(8'hFF);
        send_bytes(pkt);
        pkt = {};
        repeat (28) pkt.push_back(8'h00);
        send_bytes(pkt);
        send_datagram(4'd5, 16'd28, 28);
        send_datagram(4'd2, 16'd30, 30);
        send_datagram(4'd15, 16'd20, 24);
        send_datagram(4'd5, 16'd29, 33);
        send_datagram(4'd5, 16'd29, 29);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 50 : 0;
            rx_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 31 : 0;
            bytes_sent  = 0;
            while (bytes_sent < PHASE_BYTES)
                send_random_packet();
        end

        // Receiver stalls while short datagrams keep coming: input must back up.
        hold_req <= 1'b1;
        repeat (16) send_bytes('{8'($urandom), 8'($urandom), 8'($urandom)});

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[ipv4_udp_checksum_engine.f]
+incdir+design
design/udpck_pkg.sv
design/udpck_accum.sv
design/udpck_final.sv
design/ipv4_udp_checksum_engine.sv
design/udpck_checker.sv
sim/udpck_checker.sv
sim/ipv4_udp_checksum_engine_tb.sv
